/* hdl/plc_pkg.sv */
// Package for the PIN lock controller: sizes, phase, key and event codes.
// Used by pin_lock_controller_core; depends on nothing.
`timescale 1ns / 1ps

package plc_pkg;

    localparam int PIN_DIGITS = 4;
    localparam int IDX_W      = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam int POS_W      = 3;
    localparam int DIGIT_W    = 4;
    localparam int FAIL_W     = 4;
    localparam int TICK_W     = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [FAIL_W-1:0] FAIL_MAX        = '1;
    localparam logic [FAIL_W-1:0] LIMIT_RESET     = 4'd3;
    localparam logic [TICK_W-1:0] TICKS_RESET     = 16'd30;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX      = 4'd9;

    typedef logic [PIN_DIGITS-1:0][DIGIT_W-1:0] pin_t;

    typedef enum logic [1:0] {
        PH_SET     = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_LOCKED  = 2'd2,
        PH_ENTER   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KEY_DIGIT = 2'd0,
        KEY_BACK  = 2'd1,
        KEY_OK    = 2'd2,
        KEY_TICK  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_FIRST    = 4'd1,
        EV_MISMATCH = 4'd2,
        EV_STORED   = 4'd3,
        EV_VERIFIED = 4'd4,
        EV_WRONG    = 4'd5,
        EV_LOCKED   = 4'd6,
        EV_UNLOCKED = 4'd7,
        EV_IGNORED  = 4'd8
    } event_t;

    typedef enum logic [0:0] {
        REG_ATTEMPT_LIMIT = 1'b0,
        REG_LOCKOUT_TICKS = 1'b1
    } reg_index_t;

endpackage

/* hdl/pin_lock_controller_core.sv */
// Top level of the keypad PIN lock with failure count and timed lockout.
// Depends on plc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall, mode, digit) takes one word per key
//   press or one-second tick. Output channel (out_valid / out_stall) returns
//   exactly one word per input word: phase, entered_count, failures,
//   lockout_left and event_res, all showing the state after that word.
//   Configuration goes through the APB port: attempt_limit at 0x0,
//   lockout_ticks at 0x4; write only while no word is in flight.
//   A result word passes one input register, then the state update and the
//   result register; out_stall can hold it in the input register. Throughput
//   is one word per cycle while the receiver does not stall.
//   When out_stall is high and a result is held, in_stall rises as soon as
//   the input register is also full; nothing is dropped.
//   Reset puts the lock in the set-PIN phase with an empty entry, no
//   failures, no lockout, attempt_limit 3 and lockout_ticks 30. The stored
//   PIN holds no value until the first complete entry is made.
module pin_lock_controller_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plc_pkg::ADDR_W-1:0]  paddr,
    input  logic [plc_pkg::DATA_W-1:0]  pwdata,
    output logic [plc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [plc_pkg::DIGIT_W-1:0] digit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  phase,
    output logic [plc_pkg::POS_W-1:0]   entered_count,
    output logic [plc_pkg::FAIL_W-1:0]  failures,
    output logic [plc_pkg::TICK_W-1:0]  lockout_left,
    output logic [3:0]                  event_res
);
    import plc_pkg::*;

    logic [FAIL_W-1:0]  limit_reg;
    logic [TICK_W-1:0]  ticks_reg;
    reg_index_t         cfg_idx;
    logic               cfg_wr;

    logic               s1_valid_reg;
    mode_t              s1_mode_reg;
    logic [DIGIT_W-1:0] s1_digit_reg;

    phase_t             phase_reg, phase_next;
    pin_t               entry_reg, entry_next;
    pin_t               stored_reg, stored_next;
    pin_t               filled;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_dec;
    logic [FAIL_W-1:0]  fail_reg, fail_next, fail_inc;
    logic [TICK_W-1:0]  lock_reg, lock_next;
    event_t             ev;

    logic               out_valid_reg;
    phase_t             out_phase_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [FAIL_W-1:0]  out_fail_reg;
    logic [TICK_W-1:0]  out_lock_reg;
    event_t             out_ev_reg;

    logic               out_free;
    logic               fire;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ATTEMPT_LIMIT: limit_reg <= pwdata[FAIL_W-1:0];
                REG_LOCKOUT_TICKS: ticks_reg <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_ATTEMPT_LIMIT: prdata = {{(DATA_W-FAIL_W){1'b0}}, limit_reg};
            REG_LOCKOUT_TICKS: prdata = {{(DATA_W-TICK_W){1'b0}}, ticks_reg};
            default: prdata = '0;
        endcase
    end

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_mode_reg  <= mode_t'(mode);
            s1_digit_reg <= digit;
        end
    end

    // state update
    assign pos_dec  = pos_reg - POS_W'(1);
    assign fail_inc = (fail_reg == FAIL_MAX) ? fail_reg : fail_reg + FAIL_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        entry_next  = entry_reg;
        stored_next = stored_reg;
        pos_next    = pos_reg;
        fail_next   = fail_reg;
        lock_next   = lock_reg;
        ev          = EV_NONE;
        filled      = entry_reg;
        filled[pos_reg[IDX_W-1:0]] = s1_digit_reg;

        if (s1_mode_reg == KEY_TICK)
        begin
            if (phase_reg == PH_LOCKED)
            begin
                if (lock_reg <= TICK_W'(1))
                begin
                    lock_next  = '0;
                    phase_next = PH_ENTER;
                    fail_next  = '0;
                    entry_next = '0;
                    pos_next   = '0;
                    ev         = EV_UNLOCKED;
                end
                else
                begin
                    lock_next = lock_reg - TICK_W'(1);
                end
            end
        end
        else if (phase_reg == PH_LOCKED)
        begin
            ev = EV_IGNORED;
        end
        else if (s1_mode_reg == KEY_DIGIT)
        begin
            if (s1_digit_reg > DIGIT_MAX)
            begin
                ev = EV_IGNORED;
            end
            else if (pos_reg == POS_W'(PIN_DIGITS - 1))
            begin
                // full entry: submit and clear
                entry_next = '0;
                pos_next   = '0;
                unique case (phase_reg)
                    PH_SET:
                    begin
                        stored_next = filled;
                        phase_next  = PH_CONFIRM;
                        ev          = EV_FIRST;
                    end
                    PH_CONFIRM:
                    begin
                        if (filled == stored_reg)
                        begin
                            phase_next = PH_ENTER;
                            ev         = EV_STORED;
                        end
                        else
                        begin
                            phase_next = PH_SET;
                            ev         = EV_MISMATCH;
                        end
                    end
                    PH_ENTER:
                    begin
                        if (filled == stored_reg)
                        begin
                            fail_next = '0;
                            ev        = EV_VERIFIED;
                        end
                        else
                        begin
                            fail_next = fail_inc;
                            if (fail_inc >= limit_reg)
                            begin
                                phase_next = PH_LOCKED;
                                lock_next  = ticks_reg;
                                ev         = EV_LOCKED;
                            end
                            else
                            begin
                                ev = EV_WRONG;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                entry_next = filled;
                pos_next   = pos_reg + POS_W'(1);
            end
        end
        else if (s1_mode_reg == KEY_BACK)
        begin
            if (pos_reg != '0)
            begin
                pos_next = pos_dec;
                entry_next[pos_dec[IDX_W-1:0]] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SET;
            entry_reg <= '0;
            pos_reg   <= '0;
            fail_reg  <= '0;
            lock_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            entry_reg <= entry_next;
            pos_reg   <= pos_next;
            fail_reg  <= fail_next;
            lock_reg  <= lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            stored_reg <= stored_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_phase_reg <= phase_next;
            out_pos_reg   <= pos_next;
            out_fail_reg  <= fail_next;
            out_lock_reg  <= lock_next;
            out_ev_reg    <= ev;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase         = out_phase_reg;
    assign entered_count = out_pos_reg;
    assign failures      = out_fail_reg;
    assign lockout_left  = out_lock_reg;
    assign event_res     = out_ev_reg;

    // checks
    a_lock_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_LOCKED) |-> (lock_reg == '0))
        else $error("lockout counter running outside lockout");

    a_entry_short: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(PIN_DIGITS))
        else $error("entry buffer held full");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word produced no result");

endmodule

/* tb/tb.sv */
// Self-checking bench for the keypad PIN lock core: random and directed key words,
// bursty sender, stalling receiver, APB setting changes, on-the-fly prediction.
// Depends on plc_pkg and pin_lock_controller_core.
`timescale 1ns / 1ps

module tb;
    import plc_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 80;

    typedef struct packed {
        mode_t             key;
        logic [DIGIT_W-1:0] val;
    } key_word_t;

    typedef struct packed {
        phase_t             ph;
        logic [POS_W-1:0]   cnt;
        logic [FAIL_W-1:0]  fails;
        logic [TICK_W-1:0]  left;
        event_t             ev;
    } lock_word_t;

    typedef struct packed {
        phase_t             ph;
        pin_t               entry;
        pin_t               pin;
        logic [POS_W-1:0]   pos;
        logic [FAIL_W-1:0]  fails;
        logic [TICK_W-1:0]  left;
        logic [FAIL_W-1:0]  limit;
        logic [TICK_W-1:0]  ticks;
    } lock_state_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          mode = KEY_DIGIT;
    logic [DIGIT_W-1:0]  digit = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          phase;
    logic [POS_W-1:0]    entered_count;
    logic [FAIL_W-1:0]   failures;
    logic [TICK_W-1:0]   lockout_left;
    logic [3:0]          event_res;

    key_word_t   key_queue[$];
    lock_word_t  due_words[$];
    lock_state_t lock_shadow;
    lock_state_t plan_lock;

    int  err_count = 0;
    int  idle_cycles = 0;
    int  keys_sent = 0;
    int  words_seen = 0;
    int  setting_writes = 0;
    int  hold_token = 0;
    int  ev_seen[0:8];
    bit  aim_right = 1'b0;

    pin_lock_controller_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .digit         (digit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .phase         (phase),
        .entered_count (entered_count),
        .failures      (failures),
        .lockout_left  (lockout_left),
        .event_res     (event_res)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    task automatic step_lock(inout lock_state_t s, input mode_t key,
                             input logic [DIGIT_W-1:0] val, output lock_word_t w);
        event_t ev;
        ev = EV_NONE;
        if (key == KEY_TICK)
        begin
            if (s.ph == PH_LOCKED)
            begin
                if (s.left <= 16'd1)
                begin
                    s.left  = '0;
                    s.ph    = PH_ENTER;
                    s.fails = '0;
                    s.entry = '0;
                    s.pos   = '0;
                    ev      = EV_UNLOCKED;
                end
                else
                begin
                    s.left = s.left - 16'd1;
                end
            end
        end
        else if (s.ph == PH_LOCKED)
        begin
            ev = EV_IGNORED;
        end
        else if (key == KEY_DIGIT)
        begin
            if (val > DIGIT_MAX)
            begin
                ev = EV_IGNORED;
            end
            else if (s.pos < PIN_DIGITS)
            begin
                s.entry[s.pos[IDX_W-1:0]] = val;
                s.pos = s.pos + 3'd1;
                if (s.pos >= PIN_DIGITS)
                begin
                    case (s.ph)
                        PH_SET:
                        begin
                            s.pin = s.entry;
                            s.ph  = PH_CONFIRM;
                            ev    = EV_FIRST;
                        end
                        PH_CONFIRM:
                        begin
                            if (s.entry == s.pin)
                            begin
                                s.ph = PH_ENTER;
                                ev   = EV_STORED;
                            end
                            else
                            begin
                                s.ph = PH_SET;
                                ev   = EV_MISMATCH;
                            end
                        end
                        PH_ENTER:
                        begin
                            if (s.entry == s.pin)
                            begin
                                s.fails = '0;
                                ev      = EV_VERIFIED;
                            end
                            else
                            begin
                                if (s.fails != FAIL_MAX)
                                    s.fails = s.fails + 4'd1;
                                if (s.fails >= s.limit)
                                begin
                                    s.ph   = PH_LOCKED;
                                    s.left = s.ticks;
                                    ev     = EV_LOCKED;
                                end
                                else
                                begin
                                    ev = EV_WRONG;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    s.entry = '0;
                    s.pos   = '0;
                end
            end
        end
        else if (key == KEY_BACK && s.pos != 0)
        begin
            s.pos = s.pos - 3'd1;
            s.entry[s.pos[IDX_W-1:0]] = '0;
        end
        w.ph    = s.ph;
        w.cnt   = s.pos;
        w.fails = s.fails;
        w.left  = s.left;
        w.ev    = ev;
    endtask

    // Sender: bursts of words separated by random gaps; hold payload while stalled.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        key_word_t k;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (key_queue.size() > 0)
            begin
                k = key_queue.pop_front();
                in_valid <= 1'b1;
                mode     <= k.key;
                digit    <= k.val;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall segments of random density, plus a long hold on request.
    int seg_left = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(8, 60);
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        default: stall_pct = 70;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Predict on input accept, check on output accept.
    always @(posedge clk)
    begin
        lock_word_t w;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                step_lock(lock_shadow, mode_t'(mode), digit, w);
                due_words.push_back(w);
                keys_sent++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (due_words.size() == 0)
                begin
                    flag_error($sformatf(
                        "unexpected result ph=%0d cnt=%0d f=%0d left=%0d ev=%0d",
                        phase, entered_count, failures, lockout_left, event_res));
                end
                else
                begin
                    w = due_words.pop_front();
                    words_seen++;
                    ev_seen[w.ev]++;
                    if (phase !== w.ph || entered_count !== w.cnt || failures !== w.fails
                        || lockout_left !== w.left || event_res !== w.ev)
                        flag_error($sformatf(
                            {"word %0d exp ph=%0d cnt=%0d f=%0d left=%0d ev=%0d, ",
                             "got ph=%0d cnt=%0d f=%0d left=%0d ev=%0d"},
                            words_seen, w.ph, w.cnt, w.fails, w.left, w.ev,
                            phase, entered_count, failures, lockout_left, event_res));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] got);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_setting(input reg_index_t idx, input int unsigned val);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] got;
        logic [ADDR_W-1:0] addr;
        mask = (idx == REG_ATTEMPT_LIMIT) ? 32'h0000_000F : 32'h0000_FFFF;
        addr = ADDR_W'(int'(idx) * 4);
        apb_access(1'b1, addr, ($urandom & ~mask) | (val & mask), got);
        apb_access(1'b0, addr, '0, got);
        if (got !== (val & mask))
            flag_error($sformatf("register %0d reads %0h, exp %0h", idx, got, val & mask));
        if (idx == REG_ATTEMPT_LIMIT)
        begin
            lock_shadow.limit = val[FAIL_W-1:0];
            plan_lock.limit   = val[FAIL_W-1:0];
        end
        else
        begin
            lock_shadow.ticks = val[TICK_W-1:0];
            plan_lock.ticks   = val[TICK_W-1:0];
        end
        setting_writes++;
    endtask

    task automatic push_key(input mode_t key, input logic [DIGIT_W-1:0] val);
        key_word_t k;
        lock_word_t unused;
        k.key = key;
        k.val = val;
        step_lock(plan_lock, key, val, unused);
        key_queue.push_back(k);
    endtask

    task automatic push_pin(input pin_t p);
        for (int i = 0; i < PIN_DIGITS; i++)
            push_key(KEY_DIGIT, p[i]);
    endtask

    // Mostly well-formed entries aimed at the stored PIN, with noise mixed in.
    task automatic queue_keys(input int n);
        int r;
        logic [DIGIT_W-1:0] v;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            v = DIGIT_W'($urandom_range(0, 15));
            if (plan_lock.ph == PH_LOCKED && r >= 15)
            begin
                push_key(KEY_TICK, v);
            end
            else if (r < 4)
            begin
                push_key(KEY_BACK, v);
            end
            else if (r < 7)
            begin
                push_key(KEY_OK, v);
            end
            else if (r < 9)
            begin
                push_key(KEY_TICK, v);
            end
            else if (r < 11)
            begin
                push_key(KEY_DIGIT, DIGIT_W'($urandom_range(10, 15)));
            end
            else
            begin
                if (plan_lock.pos == 0)
                    aim_right = ($urandom_range(0, 99) < 65);
                if ((plan_lock.ph == PH_CONFIRM || plan_lock.ph == PH_ENTER) && aim_right)
                    v = plan_lock.pin[plan_lock.pos[IDX_W-1:0]];
                else
                    v = DIGIT_W'($urandom_range(0, 9));
                push_key(KEY_DIGIT, v);
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (key_queue.size() != 0 || in_valid || due_words.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int tries;
        lock_shadow       = '0;
        lock_shadow.ph    = PH_SET;
        lock_shadow.limit = LIMIT_RESET;
        lock_shadow.ticks = TICKS_RESET;
        plan_lock         = lock_shadow;
        for (int i = 0; i <= 8; i++)
            ev_seen[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-entry keys, stray tick, out-of-range digit, set/mismatch/set/confirm flow.
        push_key(KEY_OK, 4'd0);
        push_key(KEY_BACK, 4'd15);
        push_key(KEY_TICK, 4'd0);
        push_key(KEY_DIGIT, 4'd15);
        push_key(KEY_DIGIT, 4'd9);
        push_key(KEY_DIGIT, 4'd5);
        push_key(KEY_BACK, 4'd0);
        push_key(KEY_DIGIT, 4'd0);
        push_key(KEY_DIGIT, 4'd9);
        push_key(KEY_DIGIT, 4'd0);
        push_pin({4'd4, 4'd3, 4'd2, 4'd1});
        push_pin({4'd0, 4'd9, 4'd0, 4'd9});
        push_pin({4'd0, 4'd9, 4'd0, 4'd9});
        wait_idle();

        // Zero attempt limit and zero lockout: first miss locks, next tick unlocks.
        write_setting(REG_ATTEMPT_LIMIT, 0);
        write_setting(REG_LOCKOUT_TICKS, 0);
        push_pin({4'd5, 4'd5, 4'd5, 4'd5});
        push_key(KEY_DIGIT, 4'd3);
        push_key(KEY_BACK, 4'd7);
        push_key(KEY_OK, 4'd8);
        push_key(KEY_TICK, 4'd0);
        wait_idle();

        queue_keys(120);
        wait_idle();

        write_setting(REG_ATTEMPT_LIMIT, 1);
        write_setting(REG_LOCKOUT_TICKS, 1);
        queue_keys(150);
        wait_idle();

        write_setting(REG_ATTEMPT_LIMIT, 15);
        write_setting(REG_LOCKOUT_TICKS, 2);
        queue_keys(150);
        hold_token++;
        wait_idle();

        write_setting(REG_ATTEMPT_LIMIT, 3);
        write_setting(REG_LOCKOUT_TICKS, 30);
        queue_keys(150);
        hold_token++;
        wait_idle();

        write_setting(REG_ATTEMPT_LIMIT, 7);
        write_setting(REG_LOCKOUT_TICKS, 5);
        queue_keys(150);
        wait_idle();

        write_setting(REG_ATTEMPT_LIMIT, 2);
        write_setting(REG_LOCKOUT_TICKS, 3);
        queue_keys(120);
        wait_idle();

        // Longest lockout: lock once, then count down a stretch of ticks.
        write_setting(REG_ATTEMPT_LIMIT, 1);
        write_setting(REG_LOCKOUT_TICKS, 65535);
        tries = 0;
        while (plan_lock.ph != PH_LOCKED && tries < 400)
        begin
            queue_keys(1);
            tries++;
        end
        repeat (40)
            push_key(KEY_TICK, DIGIT_W'($urandom_range(0, 15)));
        push_key(KEY_DIGIT, 4'd1);
        wait_idle();

        repeat (10) @(posedge clk);
        if (due_words.size() != 0)
            flag_error($sformatf("%0d results never arrived", due_words.size()));
        $display("Run covered %0d key words, %0d results, %0d register writes.",
                 keys_sent, words_seen, setting_writes);
        $display({"Events: %0d stored, %0d verified, %0d wrong, %0d locked, ",
                  "%0d unlocked, %0d ignored; %0d errors."},
                 ev_seen[EV_STORED], ev_seen[EV_VERIFIED], ev_seen[EV_WRONG],
                 ev_seen[EV_LOCKED], ev_seen[EV_UNLOCKED], ev_seen[EV_IGNORED], err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
